// File: src/fdobs_pkg.sv
// Shared types, widths and codes for the fixed-depth order book sweep block.
// No dependencies; every other file of the block imports this package.
package fdobs_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;

	localparam int PRICE_W = 48;
	localparam int SIZE_W  = 32;
	localparam int LVL_W   = 6;

	// Level index into the tables and a walk counter that can also hold DEPTH.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// A sweep stops after the table end or the result cap, whichever is first.
	localparam int SWEEP_END = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

	// The liquidity sum of up to DEPTH sizes, kept exactly.
	localparam int SUM_W = SIZE_W + $clog2(DEPTH + 1);

	typedef logic signed [PRICE_W-1:0] price_t;
	typedef logic        [SIZE_W-1:0]  size_t;
	typedef logic        [LVL_W-1:0]   lvl_t;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_SWEEP  = 2'd1,
		OP_CHECK  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_FILL   = 2'd0,
		ST_NOFILL = 2'd1,
		ST_SUFF   = 2'd2,
		ST_INSUFF = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr;    // write one level from the input item
		logic load;  // latch a sweep or check and rewind the walk
		logic step;  // evaluate the current level of the walk
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;   // the output register can take a result this cycle
		logic walk_done;  // the current step ends the walk
	} sts_t;

endpackage

// File: src/fdobs_if.sv
// Valid/ready channel interfaces for the order book input and result items.
// Depends on fdobs_pkg for the payload types.
interface fdobs_in_if;
	import fdobs_pkg::*;

	logic   valid;
	logic   ready;
	logic [1:0] op;
	logic   side;
	lvl_t   level_index;
	price_t price_ticks;
	size_t  level_size;
	size_t  order_quantity;

	modport source (
		output valid, op, side, level_index, price_ticks, level_size, order_quantity,
		input  ready
	);
	modport sink (
		input  valid, op, side, level_index, price_ticks, level_size, order_quantity,
		output ready
	);
endinterface

interface fdobs_out_if;
	import fdobs_pkg::*;

	logic   valid;
	logic   ready;
	logic [1:0] status;
	price_t fill_price;
	size_t  fill_qty;
	lvl_t   fill_level;
	logic   last;

	modport source (
		output valid, status, fill_price, fill_qty, fill_level, last,
		input  ready
	);
	modport sink (
		input  valid, status, fill_price, fill_qty, fill_level, last,
		output ready
	);
endinterface

// File: src/fdobs_ctrl.sv
// Controller state machine of the order book block: accepts items and
// sequences the level walk. Depends on fdobs_pkg.
module fdobs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_op,
	output logic              req_ready,
	input  fdobs_pkg::sts_t   sts,
	output fdobs_pkg::cmd_t   cmd
);
	import fdobs_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t state_q;
	logic   is_walk_op;

	assign is_walk_op = (req_op == OP_SWEEP) || (req_op == OP_CHECK);
	assign req_ready  = (state_q == S_IDLE);

	always_comb begin
		cmd.wr   = (state_q == S_IDLE) && req_valid && (req_op == OP_UPDATE);
		cmd.load = (state_q == S_IDLE) && req_valid && is_walk_op;
		cmd.step = (state_q == S_WALK) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (cmd.step && sts.walk_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/fdobs_dp.sv
// Datapath of the order book block: level tables, walk registers, the held
// fill and the output register. Depends on fdobs_pkg and fdobs_out_if.
module fdobs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fdobs_pkg::cmd_t      cmd,
	output fdobs_pkg::sts_t      sts,
	input  logic [1:0]           in_op,
	input  logic                 in_side,
	input  fdobs_pkg::lvl_t      in_level_index,
	input  fdobs_pkg::price_t    in_price,
	input  fdobs_pkg::size_t     in_size,
	input  fdobs_pkg::size_t     in_qty,
	fdobs_out_if.source          res
);
	import fdobs_pkg::*;

	// Level tables. A level's valid bit records price and size both above zero.
	price_t bid_price_q [DEPTH];
	size_t  bid_size_q  [DEPTH];
	logic   bid_vld_q   [DEPTH];
	price_t ask_price_q [DEPTH];
	size_t  ask_size_q  [DEPTH];
	logic   ask_vld_q   [DEPTH];

	// Walk state.
	logic             check_q;
	logic             side_q;
	size_t            rem_q;
	price_t           limit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;

	// Fill held until the next level tells whether it is the last one.
	logic   pend_vld_q;
	price_t pend_price_q;
	size_t  pend_qty_q;
	lvl_t   pend_level_q;

	// Output register.
	logic        out_vld_q;
	status_t     out_status_q;
	price_t      out_price_q;
	size_t       out_qty_q;
	lvl_t        out_level_q;
	logic        out_last_q;

	logic [IDX_W-1:0] rd_idx;
	logic             lv_ok;
	price_t           lv_price;
	size_t            lv_size;
	logic             at_end;
	logic             crossed;
	logic             sw_go;
	logic             ck_go;
	logic             ck_hit;
	size_t            take;
	logic [SUM_W-1:0] sum_nxt;
	logic             wr_in_range;
	logic             lv_wr_ok;

	assign rd_idx = cnt_q[IDX_W-1:0];

	always_comb begin
		if (check_q) begin
			at_end = (cnt_q == CNT_W'(DEPTH));
		end else begin
			at_end = (cnt_q == CNT_W'(SWEEP_END));
		end
		// A buy walks the asks, a sell walks the bids.
		if (side_q) begin
			lv_ok    = bid_vld_q[rd_idx];
			lv_price = bid_price_q[rd_idx];
			lv_size  = bid_size_q[rd_idx];
			crossed  = lv_price < limit_q;
		end else begin
			lv_ok    = ask_vld_q[rd_idx];
			lv_price = ask_price_q[rd_idx];
			lv_size  = ask_size_q[rd_idx];
			crossed  = lv_price > limit_q;
		end
		take    = (rem_q < lv_size) ? rem_q : lv_size;
		sw_go   = !at_end && lv_ok && (rem_q != '0);
		ck_go   = !at_end && lv_ok && !crossed;
		sum_nxt = sum_q + SUM_W'(lv_size);
		ck_hit  = sum_nxt >= SUM_W'(rem_q);
	end

	always_comb begin
		sts.out_free  = !out_vld_q || res.ready;
		sts.walk_done = check_q ? (!ck_go || ck_hit) : !sw_go;
	end

	assign wr_in_range = {1'b0, in_level_index} < (LVL_W + 1)'(DEPTH);
	assign lv_wr_ok    = (in_price > price_t'(0)) && (in_size != '0);

	// Tables: valid bits reset, price and size do not need it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				bid_vld_q[i] <= 1'b0;
				ask_vld_q[i] <= 1'b0;
			end
		end else if (cmd.wr && wr_in_range) begin
			if (in_side) begin
				ask_vld_q[in_level_index[IDX_W-1:0]] <= lv_wr_ok;
			end else begin
				bid_vld_q[in_level_index[IDX_W-1:0]] <= lv_wr_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_in_range) begin
			if (in_side) begin
				ask_price_q[in_level_index[IDX_W-1:0]] <= in_price;
				ask_size_q[in_level_index[IDX_W-1:0]]  <= in_size;
			end else begin
				bid_price_q[in_level_index[IDX_W-1:0]] <= in_price;
				bid_size_q[in_level_index[IDX_W-1:0]]  <= in_size;
			end
		end
	end

	// Walk control registers. A check offers its single result only on the
	// step that ends its walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q      <= '0;
				pend_vld_q <= 1'b0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (!check_q) begin
					pend_vld_q <= sw_go;
				end
			end
			if (cmd.step && (check_q ? sts.walk_done : (!sw_go || pend_vld_q))) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Walk payload and output payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			check_q <= (in_op == OP_CHECK);
			side_q  <= in_side;
			rem_q   <= in_qty;
			limit_q <= in_price;
			sum_q   <= '0;
		end else if (cmd.step) begin
			if (check_q) begin
				sum_q        <= sum_nxt;
				out_status_q <= (ck_go && ck_hit) ? ST_SUFF : ST_INSUFF;
				out_price_q  <= '0;
				out_qty_q    <= '0;
				out_level_q  <= '0;
				out_last_q   <= 1'b1;
			end else if (sw_go) begin
				rem_q        <= rem_q - take;
				pend_price_q <= lv_price;
				pend_qty_q   <= take;
				pend_level_q <= LVL_W'(rd_idx);
				// The held fill is followed by this one, so it is not the last.
				out_status_q <= ST_FILL;
				out_price_q  <= pend_price_q;
				out_qty_q    <= pend_qty_q;
				out_level_q  <= pend_level_q;
				out_last_q   <= 1'b0;
			end else begin
				out_last_q <= 1'b1;
				if (pend_vld_q) begin
					out_status_q <= ST_FILL;
					out_price_q  <= pend_price_q;
					out_qty_q    <= pend_qty_q;
					out_level_q  <= pend_level_q;
				end else begin
					out_status_q <= ST_NOFILL;
					out_price_q  <= '0;
					out_qty_q    <= '0;
					out_level_q  <= '0;
				end
			end
		end
	end

	assign res.valid      = out_vld_q;
	assign res.status     = out_status_q;
	assign res.fill_price = out_price_q;
	assign res.fill_qty   = out_qty_q;
	assign res.fill_level = out_level_q;
	assign res.last       = out_last_q;

endmodule

// File: src/fixed_depth_order_book_sweep.sv
// Top level of the fixed-depth order book with market sweep and liquidity check.
// Depends on fdobs_pkg, fdobs_if, fdobs_ctrl and fdobs_dp.
//
// Usage: items arrive on the req channel and results leave on the res channel,
// both valid/ready; an item moves at a clock edge with valid and ready high.
// An update item writes one price level of the bid or ask table in the cycle
// it is accepted and gives no result; an update index at or beyond the table
// depth is dropped, and so is the unused op code. A market sweep walks the
// opposite table from level 0 up to its first empty level and gives one fill
// item per level until the quantity is used up, the last fill marked; else one
// no-fill item. A liquidity check gives a single sufficient/insufficient item.
//
// Timing: req.ready is high whenever no sweep or check is in progress, so
// updates go back to back at one per cycle. A sweep or check, once accepted,
// steps through one level per cycle while the output register can take a
// result, plus a final step that finds the end of the walk: at most
// min(DEPTH, MAX_RESULTS) levels per sweep and DEPTH per check. The walk reads
// the tables through a single read port, one level per step. Each fill of a
// sweep is held until the next level shows whether it is the last, and only
// then moves to the output register.
//
// Reset clears every level to empty at once. When the receiver stalls, the
// output register holds its item and the walk pauses in place.
module fixed_depth_order_book_sweep (
	input  logic        clk,
	input  logic        arst_n,
	fdobs_in_if.sink    req,
	fdobs_out_if.source res
);
	import fdobs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fdobs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fdobs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_op          (req.op),
		.in_side        (req.side),
		.in_level_index (req.level_index),
		.in_price       (req.price_ticks),
		.in_size        (req.level_size),
		.in_qty         (req.order_quantity),
		.res            (res)
	);

endmodule

// File: src/fdobs_chk.sv
// Port-level checker for the order book block, bound to its top level.
// Depends on fdobs_pkg and fixed_depth_order_book_sweep.
module fdobs_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic [1:0]          req_op,
	input logic                res_valid,
	input logic                res_ready,
	input logic [1:0]          res_status,
	input fdobs_pkg::price_t   res_price,
	input fdobs_pkg::size_t    res_qty,
	input fdobs_pkg::lvl_t     res_level,
	input logic                res_last
);
	import fdobs_pkg::*;

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	// After a sweep or check is accepted, req_ready drops as its walk starts.
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_op == OP_SWEEP || req_op == OP_CHECK)
		|=> !req_ready)
		else $error("item accepted while a walk is starting");

	// A fill always takes a nonzero quantity.
	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == ST_FILL) |-> (res_qty != '0))
		else $error("fill item with zero quantity");

	// Single-item results are marked last and carry zero fields.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == ST_NOFILL || res_status == ST_SUFF ||
		              res_status == ST_INSUFF)
		|-> res_last && (res_qty == '0) && (res_price == '0) && (res_level == '0))
		else $error("non-fill result not last or not zero");

endmodule

bind fixed_depth_order_book_sweep fdobs_chk u_fdobs_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_op     (req.op),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_status (res.status),
	.res_price  (res.fill_price),
	.res_qty    (res.fill_qty),
	.res_level  (res.fill_level),
	.res_last   (res.last)
);
